[hdl/business_day_counter_macros.svh]
// Assertion macros shared by the business day counter checkers.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef BUSINESS_DAY_COUNTER_MACROS_SVH
`define BUSINESS_DAY_COUNTER_MACROS_SVH

// Checked only while out of reset.
`define BDC_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("business_day_counter: check failed");

// Checked at every edge, reset included.
`define BDC_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("business_day_counter: check failed during reset");

`endif

[hdl/bdc_pkg.sv]
// Types, constants and small arithmetic helpers for the business day counter.
// No dependencies.
package bdc_pkg;

	typedef struct packed {
		logic [11:0] start_year;
		logic [3:0]  start_month;
		logic [4:0]  start_day;
		logic [11:0] end_year;
		logic [3:0]  end_month;
		logic [4:0]  end_day;
	} bdc_in_t;

	typedef struct packed {
		logic [20:0] working_days;
		logic        end_not_after_start;
	} bdc_out_t;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int MASK_W  = 7;
	localparam int DAY_W   = 21;

	// register index is the word address bit
	localparam logic REG_WEEKEND_MASK = 1'b0;

	localparam logic [MASK_W-1:0] MASK_RESET = 7'd96;

	// year bias of 400, minus one for the count of whole years before
	localparam logic [12:0] YEAR_BIAS_M1   = 13'd399;
	localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
	// floor(x/25) = (x*1311) >> 15, exact for x < 2048
	localparam logic [10:0] DIV25_MUL      = 11'd1311;
	// floor(x/7) = (x*2396746) >> 24, exact for x < 2^21
	localparam logic [21:0] DIV7_MUL       = 22'd2396746;

	function automatic logic [6:0] div25(input logic [10:0] x);
		logic [21:0] prod;
		prod = {11'b0, x} * {11'b0, DIV25_MUL};
		return prod[21:15];
	endfunction

	// Cumulative days before the month; month 0 reads as January, above 12 as December.
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			default:    d = 9'd334;
		endcase
		return d;
	endfunction

	// 8 = 1 mod 7, so the octal digit sum keeps the residue.
	function automatic logic [2:0] mod7(input logic [DAY_W-1:0] x);
		logic [5:0] s;
		logic [3:0] t;
		s = '0;
		for (int i = 0; i < 7; i++) begin
			s = s + {3'b0, x[3*i +: 3]};
		end
		t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
		if (t >= 4'd7) begin
			t = t - 4'd7;
		end
		return t[2:0];
	endfunction

	// Working days among r consecutive weekdays starting at weekday w.
	function automatic logic [2:0] window_count(input logic [MASK_W-1:0] work,
			input logic [2:0] w, input logic [2:0] r);
		logic [3:0] idx;
		logic [2:0] cnt;
		cnt = '0;
		for (int i = 0; i < 7; i++) begin
			idx = {1'b0, w} + 4'(i);
			if (idx >= 4'd7) begin
				idx = idx - 4'd7;
			end
			if (3'(i) < r && work[idx[2:0]]) begin
				cnt = cnt + 3'd1;
			end
		end
		return cnt;
	endfunction

endpackage

[hdl/bdc_day_number.sv]
// Two-stage day number unit: Gregorian date to linear day number, Sunday = 0 mod 7.
// Depends on bdc_pkg.
module bdc_day_number import bdc_pkg::*; (
	input  logic              clk,
	input  logic              en_s1,
	input  logic              en_s2,
	input  logic [11:0]       year,
	input  logic [3:0]        month,
	input  logic [4:0]        day,
	output logic [DAY_W-1:0]  day_num_s2
);

	logic [12:0] p;
	logic [12:0] p_s1;
	logic [6:0]  c_s1;
	logic [8:0]  dbm_s1;
	logic        late_s1;
	logic [4:0]  day_s1;
	logic        y4_s1;
	logic [9:0]  yq_s1;
	logic [6:0]  yc_s1;

	logic [10:0] yc25;
	logic        leap;
	logic [21:0] n_full;

	assign p = {1'b0, year} + YEAR_BIAS_M1;

	// stage 1: century counts and month table
	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_s1    <= p;
			c_s1    <= div25(p[12:2]);
			dbm_s1  <= days_before_month(month);
			late_s1 <= (month >= 4'd3);
			day_s1  <= day;
			y4_s1   <= (year[1:0] == 2'b00);
			yq_s1   <= year[11:2];
			yc_s1   <= div25({1'b0, year[11:2]});
		end
	end

	// leap: divisible by 4, and either not by 100 or also by 400
	assign yc25 = ({4'b0, yc_s1} << 4) + ({4'b0, yc_s1} << 3) + {4'b0, yc_s1};
	assign leap = y4_s1 && (({1'b0, yq_s1} != yc25) || (yc_s1[1:0] == 2'b00));

	assign n_full = {9'b0, p_s1} * {13'b0, DAYS_PER_YEAR}
		+ {11'b0, p_s1[12:2]} - {15'b0, c_s1} + {17'b0, c_s1[6:2]}
		+ {13'b0, dbm_s1} + {21'b0, late_s1 & leap} + {17'b0, day_s1};

	always_ff @(posedge clk) begin
		if (en_s2) begin
			day_num_s2 <= n_full[DAY_W-1:0];
		end
	end

endmodule

[hdl/business_day_counter.sv]
// Business day counter: for each start/end date pair, counts the days in [start, end)
// whose weekday is not set in weekend_mask (bit 0 Sunday, reset Friday and Saturday).
// A pair is taken every clock while in_stall is low; its result passes a five-stage
// pipeline (two for day numbers, one for the span, one for the divide by seven, one for
// the weekly count) and shows on out_valid. Stalls only hold stages that are full.
// weekend_mask sits at byte address 0 and must only be written while no pair is in flight.
// Depends on bdc_pkg and bdc_day_number.
module business_day_counter import bdc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bdc_in_t             in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bdc_out_t            out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	logic [MASK_W-1:0] mask_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [20:0] skey, ekey;
	logic flag_s1, flag_s2, flag_s3, flag_s4;

	logic [DAY_W-1:0] a_s2, b_s2;
	logic [DAY_W-1:0] len_s3;
	logic [2:0]       w_s3, w_s4, r_s4;
	logic [42:0]      prod;
	logic [18:0]      q_s4;

	logic [MASK_W-1:0] work;
	logic [2:0]        per_week;
	logic [21:0]       count;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_WEEKEND_MASK) begin
			mask_q <= pwdata[MASK_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_WEEKEND_MASK: prdata[MASK_W-1:0] = mask_q;
			default:          prdata = '0;
		endcase
	end

	// flow control: a stage loads when empty or when the next one loads
	assign rdy5 = !v_s5 || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;

	// lexicographic compare of the raw fields
	assign skey = {in_data.start_year, in_data.start_month, in_data.start_day};
	assign ekey = {in_data.end_year, in_data.end_month, in_data.end_day};

	bdc_day_number u_start (
		.clk        (clk),
		.en_s1      (rdy1),
		.en_s2      (rdy2),
		.year       (in_data.start_year),
		.month      (in_data.start_month),
		.day        (in_data.start_day),
		.day_num_s2 (a_s2)
	);

	bdc_day_number u_end (
		.clk        (clk),
		.en_s1      (rdy1),
		.en_s2      (rdy2),
		.year       (in_data.end_year),
		.month      (in_data.end_month),
		.day        (in_data.end_day),
		.day_num_s2 (b_s2)
	);

	always_ff @(posedge clk) begin
		if (rdy1) flag_s1 <= (ekey <= skey);
		if (rdy2) flag_s2 <= flag_s1;
	end

	// stage 3: span length and starting weekday
	always_ff @(posedge clk) begin
		if (rdy3) begin
			flag_s3 <= flag_s2;
			len_s3  <= (!flag_s2 && b_s2 > a_s2) ? (b_s2 - a_s2) : '0;
			w_s3    <= mod7(a_s2);
		end
	end

	// stage 4: whole weeks and leftover days
	assign prod = {22'b0, len_s3} * {21'b0, DIV7_MUL};

	always_ff @(posedge clk) begin
		if (rdy4) begin
			flag_s4 <= flag_s3;
			q_s4    <= prod[42:24];
			r_s4    <= mod7(len_s3);
			w_s4    <= w_s3;
		end
	end

	// stage 5: weekly count plus partial week
	assign work     = ~mask_q;
	assign per_week = 3'($countones(work));
	assign count    = {3'b0, q_s4} * {19'b0, per_week}
		+ {19'b0, window_count(work, w_s4, r_s4)};

	always_ff @(posedge clk) begin
		if (rdy5) begin
			out_data.working_days        <= count[20:0];
			out_data.end_not_after_start <= flag_s4;
		end
	end

endmodule

[hdl/bdc_checker.sv]
// Port-level checks for business_day_counter, attached by bind.
// Depends on bdc_pkg and business_day_counter_macros.svh.
`include "business_day_counter_macros.svh"

module bdc_checker import bdc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input bdc_in_t             in_data,
	input logic                out_valid,
	input logic                out_stall,
	input bdc_out_t            out_data,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [PADDR_W-1:0]  paddr,
	input logic [PDATA_W-1:0]  pwdata,
	input logic [PDATA_W-1:0]  prdata,
	input logic                pready
);

	// no result shows while reset is held
	`BDC_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid)

	// an empty range never carries a count
	`BDC_ASSERT(a_flag_zero_count, (out_valid && out_data.end_not_after_start) |-> (out_data.working_days == '0))

	// a held transfer keeps its result
	`BDC_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))

	// the mask reads back what was last written
	`BDC_ASSERT(a_mask_readback, (psel && penable && pwrite && pready && !paddr[2]) |=> (paddr[2] || prdata[MASK_W-1:0] == $past(pwdata[MASK_W-1:0])))

endmodule

bind business_day_counter bdc_checker u_bdc_checker (.*);

[sim/business_day_counter_test.sv]
// Self-checking testbench for business_day_counter: date pairs in over valid/stall,
// counts out, weekend mask written over the APB port between phases.
// Depends on bdc_pkg and the business_day_counter RTL.
module business_day_counter_test import bdc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] ADDR_WEEKEND_MASK = {REG_WEEKEND_MASK, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED     = {~REG_WEEKEND_MASK, 2'b00};
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 180;
	localparam int HOLD_CYCLES  = 150;
	localparam int SETTLE_CYCLES = 20;

	// Predicts one count per accepted date pair and checks results in order.
	class day_count_board;
		logic [MASK_W-1:0] off_days;
		bdc_out_t due_counts[$];
		int errors;

		function new();
			off_days = MASK_RESET;
			errors = 0;
		endfunction

		function void set_mask(logic [MASK_W-1:0] m);
			off_days = m;
		endfunction

		function int unsigned day_num(logic [11:0] y, logic [3:0] m, logic [4:0] d);
			int unsigned cum[12];
			int unsigned yy, p, n, mi;
			cum = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
			yy = y;
			p = yy + 399;
			n = 365 * p + p / 4 - p / 100 + p / 400;
			mi = m;
			if (mi < 1) mi = 1;
			if (mi > 12) mi = 12;
			n += cum[mi-1];
			// leap test on the unbiased year; year zero counts as leap
			if (mi > 2 && (((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0)))
				n += 1;
			return n + d;
		endfunction

		function bdc_out_t count_days(bdc_in_t p);
			logic [20:0] skey, ekey;
			int unsigned a, b, span, cnt, wd;
			bdc_out_t res;
			skey = {p.start_year, p.start_month, p.start_day};
			ekey = {p.end_year, p.end_month, p.end_day};
			cnt = 0;
			res.end_not_after_start = (ekey <= skey);
			if (!res.end_not_after_start) begin
				a = day_num(p.start_year, p.start_month, p.start_day);
				b = day_num(p.end_year, p.end_month, p.end_day);
				if (b > a) begin
					span = b - a;
					cnt = (span / 7) * (7 - $countones(off_days));
					wd = a % 7;
					for (int i = 0; i < span % 7; i++) begin
						if (!off_days[wd]) cnt++;
						wd = (wd == 6) ? 0 : wd + 1;
					end
				end
			end
			res.working_days = cnt[DAY_W-1:0];
			return res;
		endfunction

		function void note_pair(bdc_in_t p);
			due_counts.push_back(count_days(p));
		endfunction

		function void check_count(bdc_out_t got);
			bdc_out_t want;
			if (due_counts.size() == 0) begin
				$error("result with no pair outstanding: working_days %0d flag %0b",
					got.working_days, got.end_not_after_start);
				errors++;
				return;
			end
			want = due_counts.pop_front();
			if (got.working_days !== want.working_days) begin
				$error("working_days: expected %0d, actual %0d",
					want.working_days, got.working_days);
				errors++;
			end
			if (got.end_not_after_start !== want.end_not_after_start) begin
				$error("end_not_after_start: expected %0b, actual %0b",
					want.end_not_after_start, got.end_not_after_start);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid = 1'b0;
	logic               in_stall;
	bdc_in_t            in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	bdc_out_t           out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	day_count_board board = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;

	business_day_counter i_dut (
		.clk, .arst_n,
		.in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: check each transfer, then pick the next stall value.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_count(out_data);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic int month_len(int y, int m);
		case (m)
			2: return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic logic [20:0] rand_date(int y);
		int m, d;
		m = $urandom_range(1, 12);
		d = $urandom_range(1, month_len(y, m));
		return {12'(y), 4'(m), 5'(d)};
	endfunction

	function automatic bdc_in_t pair(int sy, int sm, int sd, int ey, int em, int ed);
		return bdc_in_t'({12'(sy), 4'(sm), 5'(sd), 12'(ey), 4'(em), 5'(ed)});
	endfunction

	function automatic bdc_in_t make_pair();
		logic [20:0] s, e, t;
		int kind, y0, y1;
		kind = $urandom_range(99);
		if (kind < 55) begin
			// calendar dates, mostly ordered, near each other or far apart
			y0 = $urandom_range(0, 4095);
			if ($urandom_range(3) == 0) y1 = $urandom_range(0, 4095);
			else y1 = y0 + $urandom_range(0, 2);
			if (y1 > 4095) y1 = 4095;
			s = rand_date(y0);
			e = rand_date(y1);
			if ((kind < 40) == (e < s)) begin
				t = s;
				s = e;
				e = t;
			end
			if (kind >= 50) e = s;
		end else if (kind < 70) begin
			// out-of-range month and day fields, same or next year
			y0 = $urandom_range(0, 4095);
			y1 = (y0 < 4095) ? y0 + $urandom_range(0, 1) : y0;
			s = {12'(y0), 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31))};
			e = {12'(y1), 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31))};
		end else begin
			s = 21'($urandom);
			e = 21'($urandom);
		end
		return bdc_in_t'({s, e});
	endfunction

	// Called at a rising edge; returns at the edge of the transfer.
	task automatic send_item(input bdc_in_t item);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_pair(item);
	endtask

	task automatic stop_and_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.due_counts.size() != 0) @(posedge clk);
	endtask

	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[PADDR_W-1] == REG_WEEKEND_MASK)
			board.set_mask(data[MASK_W-1:0]);
	endtask

	function automatic logic [MASK_W-1:0] phase_mask(int ph);
		case (ph)
			0: return 7'h00;
			1: return 7'h7F;
			2: return 7'h01;
			3: return 7'h40;
			4: return 7'h41;
			7: return MASK_RESET;
			default: return 7'($urandom_range(0, 127));
		endcase
	endfunction

	initial begin
		int idle_by_mode[4];
		int stall_by_mode[4];
		// scheduled so the reset edge reaches the block after it is waiting
		arst_n <= 1'b0;
		idle_by_mode = '{0, 45, 0, 29};
		stall_by_mode = '{0, 0, 45, 29};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs under the reset mask
		send_item(pair(1, 1, 1, 4095, 12, 31));
		send_item(pair(0, 0, 0, 4095, 15, 31));
		send_item(pair(2023, 6, 15, 2023, 6, 15));       // equal dates
		send_item(pair(2023, 6, 15, 2022, 12, 31));      // end before start
		send_item(pair(2024, 2, 28, 2024, 3, 1));        // leap year
		send_item(pair(1900, 2, 28, 1900, 3, 1));        // century, not leap
		send_item(pair(2000, 2, 28, 2000, 3, 1));        // 400-year leap
		send_item(pair(2023, 2, 31, 2023, 3, 5));        // day past month end
		send_item(pair(2023, 3, 0, 2023, 3, 10));        // day zero
		send_item(pair(2023, 0, 15, 2023, 1, 20));       // month zero
		send_item(pair(2023, 12, 5, 2023, 14, 1));       // month above twelve
		send_item(pair(0, 1, 1, 0, 3, 1));               // year zero
		send_item(pair(2023, 2, 31, 2023, 3, 1));        // keys ordered, day numbers not
		send_item(pair(2023, 12, 31, 2023, 13, 1));
		send_item(pair(0, 0, 0, 0, 0, 0));
		send_item(pair(4095, 15, 31, 4095, 15, 31));
		for (int wd = 0; wd < 7; wd++)                   // one day on each weekday
			send_item(pair(2024, 1, 7 + wd, 2024, 1, 8 + wd));
		stop_and_drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			reg_write(ADDR_WEEKEND_MASK, {25'($urandom), phase_mask(ph)});
			if (ph == 3) begin
				// let the bus return to idle before the next setup cycle
				@(posedge clk);
				reg_write(ADDR_UNMAPPED, $urandom);
			end
			idle_pct = idle_by_mode[ph % 4];
			stall_pct = stall_by_mode[ph % 4];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// long receiver hold-off while the sender keeps offering
				if (ph == 0 && k == 60) hold_left = HOLD_CYCLES;
				if (ph == 1 && k == 90) stop_and_drain();
				send_item(make_pair());
			end
			stop_and_drain();
		end

		idle_pct = 0;
		stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.due_counts.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/bdc_pkg.sv
hdl/bdc_day_number.sv
hdl/business_day_counter.sv
hdl/bdc_checker.sv
sim/business_day_counter_test.sv
